// File: sv/adll_pkg.sv
package adll_pkg;

	parameter int NODE_COUNT_DEF = 1024;
	localparam int FIELD_W = 10;

	typedef logic [FIELD_W-1:0] field_t;

	typedef enum logic [1:0] {
		ACT_INS_LEFT  = 2'd0,
		ACT_INS_RIGHT = 2'd1,
		ACT_REMOVE    = 2'd2,
		ACT_READ      = 2'd3
	} action_t;

	// Entry of the right link memory; the removed mark rides along with its own write enable.
	typedef struct packed {
		logic   mark;
		field_t link;
	} rentry_t;

endpackage

// File: sv/array_doubly_linked_list.sv
// An item is taken only in S_IDLE, where the link memories are read; no new item is
// taken until it has passed the write cycles S_W1 and S_W2, which share the write
// ports of the left and right link memories. A waiting result does not stop the next
// item from being taken and written, but its result then waits in S_HOLD, in_ready low.
// Reset: asynchronous; afterwards a clearing pass over all NODE_COUNT entries zeroes
// both link memories and all removed marks, and in_ready stays low until it ends.
module array_doubly_linked_list #(
	parameter int NODE_COUNT = adll_pkg::NODE_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             action,
	input  adll_pkg::field_t       node,
	input  adll_pkg::field_t       anchor,
	output logic                   out_valid,
	input  logic                   out_ready,
	output adll_pkg::field_t       head,
	output adll_pkg::field_t       next_node,
	output adll_pkg::field_t       prev_node,
	output logic                   ignored
);

	localparam int IW = $clog2(NODE_COUNT);

	typedef logic [IW-1:0] idx_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_W1    = 5'b00100,
		S_W2    = 5'b01000,
		S_HOLD  = 5'b10000
	} state_t;

	function automatic idx_t to_idx(adll_pkg::field_t v);
		logic [31:0] w;
		w = 32'(v);
		return w[IW-1:0];
	endfunction

	// Memories
	adll_pkg::field_t  lmem [NODE_COUNT];
	adll_pkg::rentry_t rmem [NODE_COUNT];

	state_t            state_q;
	idx_t              clr_q;
	adll_pkg::field_t  head_q;
	adll_pkg::action_t act_q;
	adll_pkg::field_t  node_q;
	adll_pkg::field_t  anchor_q;
	logic              node_ok_q;
	logic              ins_ok_q;
	logic              rm_ok_q;
	logic              rm_do_q;
	adll_pkg::field_t  res_next_q;
	adll_pkg::field_t  res_prev_q;
	logic              res_ign_q;
	adll_pkg::field_t  l_rd_q;
	adll_pkg::rentry_t r_rd_q;
	logic              out_valid_q;
	adll_pkg::field_t  out_head_q;
	adll_pkg::field_t  out_next_q;
	adll_pkg::field_t  out_prev_q;
	logic              out_ign_q;

	logic              accept;
	logic              slot_free;
	adll_pkg::action_t in_act;
	logic              in_node_ok;
	logic              in_anchor_ok;
	logic              in_ins_ok;
	idx_t              l_raddr;
	idx_t              r_raddr;
	logic              l_we;
	idx_t              l_waddr;
	adll_pkg::field_t  l_wdata;
	logic              r_we_link;
	logic              r_we_mark;
	idx_t              r_waddr;
	adll_pkg::field_t  r_wlink;
	logic              r_wmark;
	adll_pkg::field_t  prior;
	adll_pkg::field_t  after;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign in_act       = adll_pkg::action_t'(action);
	assign in_node_ok   = (node != '0) && (32'(node) < NODE_COUNT);
	assign in_anchor_ok = (anchor != '0) && (32'(anchor) < NODE_COUNT) && (anchor != node);
	assign in_ins_ok    = ((in_act == adll_pkg::ACT_INS_LEFT) ||
		(in_act == adll_pkg::ACT_INS_RIGHT)) && in_node_ok && in_anchor_ok;

	// A valid insert reads the anchor's link on its side; everything else reads the node.
	assign l_raddr = (in_ins_ok && in_act == adll_pkg::ACT_INS_LEFT) ? to_idx(anchor) : to_idx(node);
	assign r_raddr = (in_ins_ok && in_act == adll_pkg::ACT_INS_RIGHT) ? to_idx(anchor) : to_idx(node);

	assign prior = l_rd_q;
	assign after = r_rd_q.link;

	always_ff @(posedge clk) begin
		if (l_we) begin
			lmem[l_waddr] <= l_wdata;
		end
		if (accept) begin
			l_rd_q <= lmem[l_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (r_we_link) begin
			rmem[r_waddr].link <= r_wlink;
		end
		if (r_we_mark) begin
			rmem[r_waddr].mark <= r_wmark;
		end
		if (accept) begin
			r_rd_q <= rmem[r_raddr];
		end
	end

	// Write sequencing: the first write cycle writes the links on the old neighbor's side,
	// the second those between node and anchor (or the removed mark), so a corrupted list
	// where a neighbor equals the node ends in the same state as the updates done in order.
	always_comb begin
		l_we      = 1'b0;
		l_waddr   = to_idx(node_q);
		l_wdata   = '0;
		r_we_link = 1'b0;
		r_we_mark = 1'b0;
		r_waddr   = to_idx(node_q);
		r_wlink   = '0;
		r_wmark   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				l_we      = 1'b1;
				l_waddr   = clr_q;
				r_we_link = 1'b1;
				r_we_mark = 1'b1;
				r_waddr   = clr_q;
			end
			S_W1: begin
				if (ins_ok_q && act_q == adll_pkg::ACT_INS_LEFT) begin
					r_we_link = 1'b1;
					r_waddr   = to_idx(prior);
					r_wlink   = node_q;
					l_we      = 1'b1;
					l_waddr   = to_idx(node_q);
					l_wdata   = prior;
				end else if (ins_ok_q && act_q == adll_pkg::ACT_INS_RIGHT) begin
					l_we      = 1'b1;
					l_waddr   = to_idx(after);
					l_wdata   = node_q;
					r_we_link = 1'b1;
					r_we_mark = 1'b1;
					r_waddr   = to_idx(node_q);
					r_wlink   = after;
				end else if (rm_ok_q && !r_rd_q.mark) begin
					r_we_link = 1'b1;
					r_waddr   = to_idx(prior);
					r_wlink   = after;
					l_we      = 1'b1;
					l_waddr   = to_idx(after);
					l_wdata   = prior;
				end
			end
			S_W2: begin
				if (ins_ok_q && act_q == adll_pkg::ACT_INS_LEFT) begin
					r_we_link = 1'b1;
					r_we_mark = 1'b1;
					r_waddr   = to_idx(node_q);
					r_wlink   = anchor_q;
					l_we      = 1'b1;
					l_waddr   = to_idx(anchor_q);
					l_wdata   = node_q;
				end else if (ins_ok_q && act_q == adll_pkg::ACT_INS_RIGHT) begin
					l_we      = 1'b1;
					l_waddr   = to_idx(node_q);
					l_wdata   = anchor_q;
					r_we_link = 1'b1;
					r_waddr   = to_idx(anchor_q);
					r_wlink   = node_q;
				end else if (rm_do_q) begin
					r_we_mark = 1'b1;
					r_waddr   = to_idx(node_q);
					r_wmark   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			head_q      <= adll_pkg::field_t'(1);
			out_valid_q <= 1'b0;
			rm_do_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_W2 && state_q != S_HOLD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == idx_t'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_W1;
					end
				end
				S_W1: begin
					rm_do_q <= rm_ok_q && !r_rd_q.mark;
					if (ins_ok_q && act_q == adll_pkg::ACT_INS_LEFT && prior == '0) begin
						head_q <= node_q;
					end else if (rm_ok_q && !r_rd_q.mark && prior == '0) begin
						head_q <= after;
					end
					state_q <= S_W2;
				end
				S_W2, S_HOLD: begin
					rm_do_q <= 1'b0;
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_HOLD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item and result payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= in_act;
			node_q    <= node;
			anchor_q  <= anchor;
			node_ok_q <= in_node_ok;
			ins_ok_q  <= in_ins_ok;
			rm_ok_q   <= (in_act == adll_pkg::ACT_REMOVE) && in_node_ok;
		end
		if (state_q == S_W1) begin
			res_ign_q <= rm_ok_q && r_rd_q.mark;
			if (ins_ok_q && act_q == adll_pkg::ACT_INS_LEFT) begin
				res_next_q <= anchor_q;
				res_prev_q <= prior;
			end else if (ins_ok_q && act_q == adll_pkg::ACT_INS_RIGHT) begin
				res_next_q <= after;
				res_prev_q <= anchor_q;
			end else if (node_ok_q) begin
				res_next_q <= after;
				res_prev_q <= prior;
			end else begin
				res_next_q <= '0;
				res_prev_q <= '0;
			end
		end
		if ((state_q == S_W2 || state_q == S_HOLD) && slot_free) begin
			out_head_q <= head_q;
			out_next_q <= res_next_q;
			out_prev_q <= res_prev_q;
			out_ign_q  <= res_ign_q;
		end
	end

	assign out_valid = out_valid_q;
	assign head      = out_head_q;
	assign next_node = out_next_q;
	assign prev_node = out_prev_q;
	assign ignored   = out_ign_q;

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted while another is in flight");

	a_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_W1) ##1 (state_q == S_W2))
		else $error("write cycles did not follow the read");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < NODE_COUNT)
		else $error("head beyond the link store");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_W2 || state_q == S_HOLD))
		else $error("result raised outside the final write cycle");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int NODES = adll_pkg::NODE_COUNT_DEF;
	localparam int DIRECT_WALK = 6;
	localparam int RANDOM_OPS = 1750;
	localparam int ROUND_LEN = 250;
	localparam int HOLD_AT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 20;

	// Two copies of the list state: one that the stimulus plans against, one that
	// follows the items as the block accepts them.
	localparam int PLANNED = 0;
	localparam int ACCEPTED = 1;

	typedef struct packed {
		adll_pkg::action_t action;
		adll_pkg::field_t  node;
		adll_pkg::field_t  anchor;
	} list_op_t;

	typedef struct packed {
		adll_pkg::field_t head;
		adll_pkg::field_t next_node;
		adll_pkg::field_t prev_node;
		logic             ignored;
	} link_report_t;

	typedef enum int {PICK_MEMBER, PICK_REMOVED, PICK_KNOWN, PICK_UNUSED} pick_t;
	typedef enum int {GROW, MIXED, SHRINK} round_t;
	typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_style_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       action = adll_pkg::ACT_READ;
	adll_pkg::field_t node = '0;
	adll_pkg::field_t anchor = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	adll_pkg::field_t head;
	adll_pkg::field_t next_node;
	adll_pkg::field_t prev_node;
	logic             ignored;

	adll_pkg::field_t left_of [2][NODES];
	adll_pkg::field_t right_of [2][NODES];
	bit               left_set [2][NODES];
	bit               right_set [2][NODES];
	bit               gone [2][NODES];
	adll_pkg::field_t head_of [2];

	list_op_t         ops_pending[$];
	link_report_t     reports_due[$];
	list_op_t         op_on_bus;
	adll_pkg::field_t walk_at = '0;

	int unsigned mismatches = 0;
	int unsigned ops_accepted = 0;
	int unsigned reports_checked = 0;
	int unsigned flagged_removals = 0;
	int unsigned empty_reports = 0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 1;
	int unsigned quiet_cycles = 0;
	int unsigned rx_cycle = 0;
	int unsigned hold_left = 0;
	int unsigned style_left = 0;
	rx_style_t   rx_style = RX_OPEN;

	array_doubly_linked_list #(.NODE_COUNT(NODES)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void set_left(int unsigned c, adll_pkg::field_t at,
		adll_pkg::field_t val);
		left_of[c][at] = val;
		left_set[c][at] = 1'b1;
	endfunction

	function automatic void set_right(int unsigned c, adll_pkg::field_t at,
		adll_pkg::field_t val);
		right_of[c][at] = val;
		right_set[c][at] = 1'b1;
	endfunction

	// Applies one list operation to copy c and returns the head and the links of the
	// named node afterwards.
	function automatic link_report_t apply_list_op(int unsigned c, list_op_t op);
		link_report_t     r;
		bit               node_ok;
		adll_pkg::field_t nb_left;
		adll_pkg::field_t nb_right;
		r = '0;
		node_ok = op.node != 0 && op.node < NODES;
		case (op.action)
			adll_pkg::ACT_INS_LEFT, adll_pkg::ACT_INS_RIGHT: begin
				if (node_ok && op.anchor != 0 && op.anchor < NODES && op.anchor != op.node) begin
					if (op.action == adll_pkg::ACT_INS_RIGHT) begin
						nb_right = right_of[c][op.anchor];
						set_left(c, nb_right, op.node);
						set_right(c, op.node, nb_right);
						set_left(c, op.node, op.anchor);
						set_right(c, op.anchor, op.node);
					end else begin
						nb_left = left_of[c][op.anchor];
						set_right(c, nb_left, op.node);
						set_left(c, op.node, nb_left);
						set_right(c, op.node, op.anchor);
						set_left(c, op.anchor, op.node);
					end
					gone[c][op.node] = 1'b0;
					if (left_of[c][op.node] == 0)
						head_of[c] = op.node;
				end
			end
			adll_pkg::ACT_REMOVE: begin
				if (node_ok) begin
					if (gone[c][op.node]) begin
						r.ignored = 1'b1;
					end else begin
						nb_left = left_of[c][op.node];
						nb_right = right_of[c][op.node];
						set_right(c, nb_left, nb_right);
						set_left(c, nb_right, nb_left);
						if (nb_left == 0)
							head_of[c] = nb_right;
						gone[c][op.node] = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.head = head_of[c];
		if (node_ok) begin
			r.next_node = right_of[c][op.node];
			r.prev_node = left_of[c][op.node];
		end
		return r;
	endfunction

	// True when the operation reads no link entry that was never written.
	function automatic bit op_is_safe(list_op_t op);
		bit known;
		bit ok;
		known = left_set[PLANNED][op.node] && right_set[PLANNED][op.node];
		ok = known;
		if (op.node == 0) begin
			ok = 1'b1;
		end else begin
			case (op.action)
				adll_pkg::ACT_INS_LEFT, adll_pkg::ACT_INS_RIGHT: begin
					if (op.anchor != 0 && op.anchor != op.node)
						ok = op.action == adll_pkg::ACT_INS_LEFT
							? left_set[PLANNED][op.anchor]
							: right_set[PLANNED][op.anchor];
				end
				adll_pkg::ACT_REMOVE: ok = gone[PLANNED][op.node] || known;
				default: ;
			endcase
		end
		return ok;
	endfunction

	function automatic adll_pkg::field_t pick_node(pick_t kind);
		int unsigned hits[$];
		bit          known;
		for (int n = 1; n < NODES; n++) begin
			known = left_set[PLANNED][n] && right_set[PLANNED][n];
			case (kind)
				PICK_MEMBER: if (known && !gone[PLANNED][n]) hits.push_back(n);
				PICK_REMOVED: if (gone[PLANNED][n]) hits.push_back(n);
				PICK_KNOWN: if (known) hits.push_back(n);
				default: if (!known && !gone[PLANNED][n]) hits.push_back(n);
			endcase
		end
		if (hits.size() == 0)
			return '0;
		return adll_pkg::field_t'(hits[$urandom_range(hits.size() - 1)]);
	endfunction

	task automatic queue_op(adll_pkg::action_t act, adll_pkg::field_t n,
		adll_pkg::field_t an);
		list_op_t op;
		op = '{act, n, an};
		void'(apply_list_op(PLANNED, op));
		ops_pending.push_back(op);
	endtask

	function automatic list_op_t random_op(round_t mode);
		list_op_t    op;
		int unsigned roll;
		int unsigned sub;
		int unsigned ins_pct;
		int unsigned rem_pct;
		op.action = adll_pkg::ACT_READ;
		op.node = adll_pkg::field_t'($urandom);
		op.anchor = adll_pkg::field_t'($urandom);
		ins_pct = mode == GROW ? 50 : mode == MIXED ? 30 : 5;
		rem_pct = mode == GROW ? 12 : mode == MIXED ? 25 : 70;
		roll = $urandom_range(99);
		sub = $urandom_range(99);
		if (roll < ins_pct) begin
			op.action = $urandom_range(1) ? adll_pkg::ACT_INS_RIGHT : adll_pkg::ACT_INS_LEFT;
			op.anchor = pick_node(PICK_MEMBER);
			if (op.anchor == 0 || $urandom_range(9) == 0)
				op.anchor = pick_node(PICK_KNOWN);
			if (sub < 80) begin
				op.node = pick_node(PICK_UNUSED);
				if (op.node == 0)
					op.node = pick_node(PICK_REMOVED);
			end else if (sub < 92) begin
				op.node = pick_node(PICK_REMOVED);
			end else if (sub < 96) begin
				// Inserting a current member scrambles the order; the block must still
				// follow the same link writes.
				op.node = pick_node(PICK_MEMBER);
			end else begin
				op.node = pick_node(PICK_KNOWN);
				case ($urandom_range(2))
					0: op.node = '0;
					1: op.anchor = '0;
					default: op.anchor = op.node;
				endcase
			end
		end else if (roll < ins_pct + rem_pct) begin
			op.action = adll_pkg::ACT_REMOVE;
			if (sub < 80)
				op.node = pick_node(PICK_MEMBER);
			else if (sub < 95)
				op.node = pick_node(PICK_REMOVED);
			else
				op.node = '0;
		end else begin
			if (sub < 50) begin
				// Walk the list to the right, one read per item, restarting at the head.
				if (walk_at == 0)
					walk_at = head_of[PLANNED];
				op.node = walk_at;
				walk_at = walk_at == 0 ? adll_pkg::field_t'(0) : right_of[PLANNED][walk_at];
			end else if (sub < 90) begin
				op.node = pick_node(PICK_KNOWN);
			end else begin
				op.node = '0;
			end
		end
		return op;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	initial begin : stimulus
		list_op_t    cand;
		int unsigned tries;
		for (int c = 0; c < 2; c++) begin
			for (int n = 0; n < NODES; n++) begin
				left_of[c][n] = '0;
				right_of[c][n] = '0;
				left_set[c][n] = 1'b0;
				right_set[c][n] = 1'b0;
				gone[c][n] = 1'b0;
			end
			left_set[c][1] = 1'b1;
			right_set[c][1] = 1'b1;
			head_of[c] = adll_pkg::field_t'(1);
		end

		queue_op(adll_pkg::ACT_READ, 10'd1, 10'd1023);
		queue_op(adll_pkg::ACT_READ, 10'd0, 10'd0);
		queue_op(adll_pkg::ACT_INS_LEFT, 10'd2, 10'd1);
		queue_op(adll_pkg::ACT_INS_RIGHT, 10'd1023, 10'd1);
		queue_op(adll_pkg::ACT_INS_RIGHT, 10'd3, 10'd1023);
		queue_op(adll_pkg::ACT_INS_LEFT, 10'd4, 10'd1023);
		queue_op(adll_pkg::ACT_INS_LEFT, 10'd0, 10'd1);
		queue_op(adll_pkg::ACT_INS_RIGHT, 10'd4, 10'd0);
		queue_op(adll_pkg::ACT_INS_LEFT, 10'd3, 10'd3);
		queue_op(adll_pkg::ACT_REMOVE, 10'd0, 10'd1023);
		queue_op(adll_pkg::ACT_REMOVE, 10'd2, 10'd0);
		queue_op(adll_pkg::ACT_REMOVE, 10'd2, 10'd512);
		queue_op(adll_pkg::ACT_REMOVE, 10'd3, 10'd0);
		queue_op(adll_pkg::ACT_READ, 10'd2, 10'd0);
		queue_op(adll_pkg::ACT_INS_RIGHT, 10'd2, 10'd1);
		queue_op(adll_pkg::ACT_INS_LEFT, 10'd5, 10'd3);
		walk_at = head_of[PLANNED];
		repeat (DIRECT_WALK) begin
			queue_op(adll_pkg::ACT_READ, walk_at, adll_pkg::field_t'($urandom));
			walk_at = walk_at == 0 ? adll_pkg::field_t'(0) : right_of[PLANNED][walk_at];
		end

		walk_at = '0;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			tries = 0;
			do begin
				cand = random_op(round_t'((i / ROUND_LEN) % 3));
				tries++;
			end while (!op_is_safe(cand) && tries < 8);
			// Node one is written from reset on, so reading it is always allowed.
			if (!op_is_safe(cand))
				cand = '{adll_pkg::ACT_READ, adll_pkg::field_t'(1),
					adll_pkg::field_t'($urandom)};
			queue_op(cand.action, cand.node, cand.anchor);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_pending.size() != 0 || in_valid || reports_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d list operations and checked %0d reports, %0d flagged removals",
			ops_accepted, reports_checked, flagged_removals);
		$display("and %0d reports with an empty list, with one long output stall.",
			empty_reports);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin : feed
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				reports_due.push_back(apply_list_op(ACCEPTED, op_on_bus));
				ops_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0 || ops_pending.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					op_on_bus = ops_pending.pop_front();
					in_valid <= 1'b1;
					action <= op_on_bus.action;
					node <= op_on_bus.node;
					anchor <= op_on_bus.anchor;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(7) == 0 ? $urandom_range(100, 200)
							: $urandom_range(1, 40);
						case ($urandom_range(3))
							0, 1: gap_left = 0;
							2: gap_left = $urandom_range(1, 4);
							default: gap_left = $urandom_range(5, 30);
						endcase
					end
				end
			end
		end
	end

	// The output side keeps its own pattern, with one long hold that lets the block
	// fill up and push back on its input.
	always @(posedge clk) begin : drain
		rx_cycle++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_cycle == HOLD_AT) begin
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				rx_style = rx_style_t'($urandom_range(2));
				style_left = $urandom_range(10, 150);
			end else begin
				style_left--;
			end
			case (rx_style)
				RX_OPEN: out_ready <= 1'b1;
				RX_CHOPPY: out_ready <= 1'($urandom_range(1));
				default: out_ready <= $urandom_range(3) == 0;
			endcase
		end
	end

	always @(posedge clk) begin : compare
		link_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reports_due.size() == 0) begin
				$error("result with no item outstanding: head %0d next %0d prev %0d",
					head, next_node, prev_node);
				mismatches++;
			end else begin
				want = reports_due.pop_front();
				check_field("head", want.head, head);
				check_field("next_node", want.next_node, next_node);
				check_field("prev_node", want.prev_node, prev_node);
				check_field("ignored", want.ignored, ignored);
				reports_checked++;
				if (want.ignored)
					flagged_removals++;
				if (want.head == 0)
					empty_reports++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// File: sim.f
sv/adll_pkg.sv
sv/array_doubly_linked_list.sv
bench/tb_top.sv
